// File: sv/pits_pkg.sv
// shared constants and types for the point in tube shell test
package pits_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RAD_W          = 15;
  localparam int IDX_W          = 3;
  localparam int CFG_DATA_W_DEF = (COORD_BITS_DEF > RAD_W) ? COORD_BITS_DEF : RAD_W;

  typedef enum logic [IDX_W-1:0] {
    REG_START_X      = 3'd0,
    REG_START_Y      = 3'd1,
    REG_START_Z      = 3'd2,
    REG_END_X        = 3'd3,
    REG_END_Y        = 3'd4,
    REG_END_Z        = 3'd5,
    REG_INNER_RADIUS = 3'd6,
    REG_OUTER_RADIUS = 3'd7
  } pits_reg_t;

  typedef struct packed {
    logic vld;
    logic rej;
  } pits_ctl_t;

endpackage

// File: sv/pits_if.sv
// channel interfaces for point beats, result beats and register writes
interface pits_in_if #(
  parameter int COORD_BITS = pits_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface pits_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

interface pits_cfg_if #(
  parameter int DATA_W = pits_pkg::CFG_DATA_W_DEF
);
  logic                       valid;
  logic                       ready;
  logic [pits_pkg::IDX_W-1:0] idx;
  logic [DATA_W-1:0]          wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

// File: sv/pits_cfg.sv
// configuration register file holding the tube axis and radii
module pits_cfg #(
  parameter int COORD_BITS = pits_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pits_cfg_if.sink                     cfg_ch,
  output logic signed [COORD_BITS-1:0] start_o [3],
  output logic signed [COORD_BITS-1:0] stop_o  [3],
  output logic [pits_pkg::RAD_W-1:0]   ri_o,
  output logic [pits_pkg::RAD_W-1:0]   ro_o
);
  import pits_pkg::*;

  logic signed [COORD_BITS-1:0] start_r [3];
  logic signed [COORD_BITS-1:0] stop_r  [3];
  logic [RAD_W-1:0]             ri_r;
  logic [RAD_W-1:0]             ro_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        stop_r[i]  <= '0;
      end
      ri_r <= '0;
      ro_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (pits_reg_t'(cfg_ch.idx))
        REG_START_X:      start_r[0] <= cfg_ch.wdata[COORD_BITS-1:0];
        REG_START_Y:      start_r[1] <= cfg_ch.wdata[COORD_BITS-1:0];
        REG_START_Z:      start_r[2] <= cfg_ch.wdata[COORD_BITS-1:0];
        REG_END_X:        stop_r[0]  <= cfg_ch.wdata[COORD_BITS-1:0];
        REG_END_Y:        stop_r[1]  <= cfg_ch.wdata[COORD_BITS-1:0];
        REG_END_Z:        stop_r[2]  <= cfg_ch.wdata[COORD_BITS-1:0];
        REG_INNER_RADIUS: ri_r       <= cfg_ch.wdata[RAD_W-1:0];
        REG_OUTER_RADIUS: ro_r       <= cfg_ch.wdata[RAD_W-1:0];
        default:          ri_r       <= ri_r;
      endcase
    end
  end

  assign start_o = start_r;
  assign stop_o  = stop_r;
  assign ri_o    = ri_r;
  assign ro_o    = ro_r;

endmodule

// File: sv/pits_front.sv
// first three stages: offsets, products, dot sums and cross product
module pits_front #(
  parameter  int COORD_BITS = pits_pkg::COORD_BITS_DEF,
  localparam int CR_W       = 2 * COORD_BITS + 3,
  localparam int LEN_W      = 2 * COORD_BITS + 2,
  localparam int SQ_W       = 2 * pits_pkg::RAD_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pits_in_if.sink                      in_ch,
  input  logic signed [COORD_BITS-1:0] start_i [3],
  input  logic signed [COORD_BITS-1:0] stop_i  [3],
  input  logic [pits_pkg::RAD_W-1:0]   ri_i,
  input  logic [pits_pkg::RAD_W-1:0]   ro_i,
  input  logic                         ready_i,
  output pits_pkg::pits_ctl_t          ctl_o,
  output logic signed [CR_W-1:0]       c_o     [3],
  output logic [LEN_W-1:0]             len2_o,
  output logic [SQ_W-1:0]              ri2_o,
  output logic [SQ_W-1:0]              ro2_o
);
  import pits_pkg::*;

  localparam int A_W   = COORD_BITS + 1;
  localparam int P_W   = 2 * COORD_BITS + 2;
  localparam int DOT_W = 2 * COORD_BITS + 4;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic signed [COORD_BITS-1:0] q [3];

  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  // stage 1
  logic signed [A_W-1:0] a_nxt [3], b_nxt [3], d_nxt [3];
  logic signed [A_W-1:0] a_r [3], b_r [3], d_r [3];

  // stage 2
  logic signed [P_W-1:0] ad_nxt [3], bd_nxt [3], dd_nxt [3], xp_nxt [3], xn_nxt [3];
  logic signed [P_W-1:0] ad_r [3], bd_r [3], dd_r [3], xp_r [3], xn_r [3];
  logic                  zero_nxt, zero_r;
  logic [SQ_W-1:0]       ri2_nxt, ro2_nxt, ri2_r2, ro2_r2;

  // stage 3
  logic signed [DOT_W-1:0] dot1_nxt, dot2_nxt;
  logic                    rej_nxt, rej_r;
  logic signed [CR_W-1:0]  c_nxt [3], c_r [3];
  logic [LEN_W-1:0]        len2_nxt, len2_r;
  logic [SQ_W-1:0]         ri2_r3, ro2_r3;

  assign q[0] = in_ch.pos_x;
  assign q[1] = in_ch.pos_y;
  assign q[2] = in_ch.pos_z;

  assign en3 = !v3_r || ready_i;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_nxt[i] = A_W'(q[i]) - A_W'(start_i[i]);
      b_nxt[i] = A_W'(q[i]) - A_W'(stop_i[i]);
      d_nxt[i] = A_W'(stop_i[i]) - A_W'(start_i[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad_nxt[i] = P_W'(a_r[i]) * P_W'(d_r[i]);
      bd_nxt[i] = P_W'(b_r[i]) * P_W'(d_r[i]);
      dd_nxt[i] = P_W'(d_r[i]) * P_W'(d_r[i]);
      xp_nxt[i] = P_W'(a_r[NXT[i]]) * P_W'(d_r[PRV[i]]);
      xn_nxt[i] = P_W'(a_r[PRV[i]]) * P_W'(d_r[NXT[i]]);
    end
    zero_nxt = (a_r[0] == '0 && a_r[1] == '0 && a_r[2] == '0) ||
               (b_r[0] == '0 && b_r[1] == '0 && b_r[2] == '0) ||
               (d_r[0] == '0 && d_r[1] == '0 && d_r[2] == '0);
    ri2_nxt = SQ_W'(ri_i) * SQ_W'(ri_i);
    ro2_nxt = SQ_W'(ro_i) * SQ_W'(ro_i);
  end

  always_comb begin
    dot1_nxt = DOT_W'(ad_r[0]) + DOT_W'(ad_r[1]) + DOT_W'(ad_r[2]);
    dot2_nxt = DOT_W'(bd_r[0]) + DOT_W'(bd_r[1]) + DOT_W'(bd_r[2]);
    rej_nxt  = zero_r || (dot1_nxt < 0) || (dot2_nxt > 0);
    len2_nxt = LEN_W'($unsigned(dd_r[0])) + LEN_W'($unsigned(dd_r[1])) +
               LEN_W'($unsigned(dd_r[2]));
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = CR_W'(xp_r[i]) - CR_W'(xn_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      d_r <= d_nxt;
    end
    if (en2) begin
      ad_r   <= ad_nxt;
      bd_r   <= bd_nxt;
      dd_r   <= dd_nxt;
      xp_r   <= xp_nxt;
      xn_r   <= xn_nxt;
      zero_r <= zero_nxt;
      ri2_r2 <= ri2_nxt;
      ro2_r2 <= ro2_nxt;
    end
    if (en3) begin
      rej_r  <= rej_nxt;
      c_r    <= c_nxt;
      len2_r <= len2_nxt;
      ri2_r3 <= ri2_r2;
      ro2_r3 <= ro2_r2;
    end
  end

  assign ctl_o.vld = v3_r;
  assign ctl_o.rej = rej_r;
  assign c_o       = c_r;
  assign len2_o    = len2_r;
  assign ri2_o     = ri2_r3;
  assign ro2_o     = ro2_r3;

`ifndef SYNTHESIS
  // an accepted beat has a nonzero axis, so its length must be nonzero
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rej_r) |-> (len2_r != '0))
    else $error("accepted beat with zero axis length");
`endif

endmodule

// File: sv/pits_back.sv
// last three stages: squared distances, bounds and the result register
module pits_back #(
  parameter  int COORD_BITS = pits_pkg::COORD_BITS_DEF,
  localparam int CR_W       = 2 * COORD_BITS + 3,
  localparam int LEN_W      = 2 * COORD_BITS + 2,
  localparam int SQ_W       = 2 * pits_pkg::RAD_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pits_pkg::pits_ctl_t    ctl_i,
  input  logic signed [CR_W-1:0] c_i [3],
  input  logic [LEN_W-1:0]       len2_i,
  input  logic [SQ_W-1:0]        ri2_i,
  input  logic [SQ_W-1:0]        ro2_i,
  output logic                   ready_o,
  pits_out_if.source             out_ch
);
  import pits_pkg::*;

  localparam int SQC_W = 4 * COORD_BITS + 4;
  localparam int BND_W = SQ_W + LEN_W;
  localparam int CMP_W = (SQC_W > BND_W) ? SQC_W : BND_W;
  localparam int MUL_W = 2 * CR_W;

  logic en4, en5, en6;
  logic v4_r, v5_r, v6_r;

  logic signed [MUL_W-1:0] sq_full [3];
  logic [SQC_W-1:0]        sq_nxt [3], sq_r [3];
  logic [CMP_W-1:0]        lo_nxt, hi_nxt, lo_r4, hi_r4;
  logic                    rej_r4, rej_r5;

  logic [CMP_W-1:0]        cr2_nxt, cr2_r, lo_r5, hi_r5;
  logic                    inside_nxt, inside_r;

  assign en6 = !v6_r || out_ch.ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign ready_o = en4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = MUL_W'(c_i[i]) * MUL_W'(c_i[i]);
      sq_nxt[i]  = sq_full[i][SQC_W-1:0];
    end
    lo_nxt = CMP_W'(ri2_i) * CMP_W'(len2_i);
    hi_nxt = CMP_W'(ro2_i) * CMP_W'(len2_i);
  end

  always_comb begin
    cr2_nxt = CMP_W'(sq_r[0]) + CMP_W'(sq_r[1]) + CMP_W'(sq_r[2]);
  end

  always_comb begin
    inside_nxt = !rej_r5 && (lo_r5 <= cr2_r) && (cr2_r <= hi_r5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= ctl_i.vld;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sq_r   <= sq_nxt;
      lo_r4  <= lo_nxt;
      hi_r4  <= hi_nxt;
      rej_r4 <= ctl_i.rej;
    end
    if (en5) begin
      cr2_r  <= cr2_nxt;
      lo_r5  <= lo_r4;
      hi_r5  <= hi_r4;
      rej_r5 <= rej_r4;
    end
    if (en6) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_ch.valid      = v6_r;
  assign out_ch.inside_res = inside_r;

`ifndef SYNTHESIS
  // a full back half with a stalled output must push back on the front
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && v5_r && v6_r && !out_ch.ready) |-> !ready_o)
    else $error("back stages full but still taking beats");

  // a beat handed over from the front lands in the first back stage
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.vld && ready_o) |=> v4_r)
    else $error("beat lost between front and back stages");
`endif

endmodule

// File: sv/point_in_tube_shell_test.sv
// top level of the point in tube shell test
// Takes one signed Q8.8 point per beat and answers whether it lies inside the
// configured tube shell: between the end caps and with a squared axis distance
// between the inner and outer radius bounds, all in exact integer arithmetic.
// A point on an end point, or a zero-length axis, gives 0; inner radius 0 is a
// solid tube. One point is accepted every clock while the result side does not
// stall; each point passes through six register stages (offsets, products,
// sums, squares, square sum, bound compare) around the multipliers, the first
// of which captures the point at its accepting edge.
// Stalls on the result side back up stage by stage, filling bubbles first.
// Registers are written through the cfg channel, which is always ready; write
// them only while no point is in flight.
module point_in_tube_shell_test #(
  parameter int COORD_BITS = pits_pkg::COORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  pits_in_if.sink     in_ch,
  pits_out_if.source  out_ch,
  pits_cfg_if.sink    cfg_ch
);
  import pits_pkg::*;

  localparam int CR_W  = 2 * COORD_BITS + 3;
  localparam int LEN_W = 2 * COORD_BITS + 2;
  localparam int SQ_W  = 2 * RAD_W;

  logic signed [COORD_BITS-1:0] start_w [3];
  logic signed [COORD_BITS-1:0] stop_w  [3];
  logic [RAD_W-1:0]             ri_w;
  logic [RAD_W-1:0]             ro_w;

  pits_ctl_t                    ctl_w;
  logic signed [CR_W-1:0]       c_w [3];
  logic [LEN_W-1:0]             len2_w;
  logic [SQ_W-1:0]              ri2_w;
  logic [SQ_W-1:0]              ro2_w;
  logic                         back_ready_w;

  pits_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .start_o (start_w),
    .stop_o  (stop_w),
    .ri_o    (ri_w),
    .ro_o    (ro_w)
  );

  pits_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .start_i (start_w),
    .stop_i  (stop_w),
    .ri_i    (ri_w),
    .ro_i    (ro_w),
    .ready_i (back_ready_w),
    .ctl_o   (ctl_w),
    .c_o     (c_w),
    .len2_o  (len2_w),
    .ri2_o   (ri2_w),
    .ro2_o   (ro2_w)
  );

  pits_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_w),
    .c_i     (c_w),
    .len2_i  (len2_w),
    .ri2_i   (ri2_w),
    .ro2_i   (ro2_w),
    .ready_o (back_ready_w),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // zero-length axis never reports a point inside
  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && start_w[0] == stop_w[0] && start_w[1] == stop_w[1] &&
     start_w[2] == stop_w[2]) |-> !out_ch.inside_res)
    else $error("inside reported for zero-length axis");

  // outer radius below inner radius leaves an empty shell
  a_empty_shell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.inside_res) |-> (ro_w >= ri_w))
    else $error("inside reported for empty shell");
`endif

endmodule
